[hdl/tpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types, constants and the type-code decoder of the packet deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam logic [7:0] BYTE_START  = 8'd129;
    localparam logic [7:0] BYTE_END    = 8'd128;
    localparam logic [7:0] ID_IDENTIFY = 8'd254;
    localparam logic [3:0] LEN_MASK    = 4'b1111;

    localparam int NUM_TYPES          = 7;
    localparam int SLOTS_PER_TYPE_DEF = 16;
    localparam int CMD_DEPTH          = 2;
    localparam int RES_DEPTH          = 2;

    localparam logic [2:0] VT_U8      = 3'd0;
    localparam logic [2:0] VT_U16     = 3'd1;
    localparam logic [2:0] VT_U32     = 3'd2;
    localparam logic [2:0] VT_S8      = 3'd3;
    localparam logic [2:0] VT_S16     = 3'd4;
    localparam logic [2:0] VT_S32     = 3'd5;
    localparam logic [2:0] VT_F32     = 3'd6;
    localparam logic [2:0] VT_INVALID = 3'd7;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_ID   = 2'd1,
        PH_TYPE = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_VALUE    = 2'd0,
        KIND_IDENTIFY = 2'd1,
        KIND_ERROR    = 2'd2,
        KIND_NONE     = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        OP_CLEAR_U8 = 2'd0,
        OP_VALUE    = 2'd1,
        OP_DONE     = 2'd2
    } cmd_op_t;

    // request passed from the parser to the slot stage
    typedef struct packed {
        cmd_op_t     op;
        event_kind_t kind;
        logic [7:0]  id;
        logic [2:0]  vtype;
        logic [31:0] bits;
    } cmd_t;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  id;
        logic [2:0]  vtype;
        logic [31:0] bits;
        logic [3:0]  slot;
        logic        overflow;
    } result_t;

    function automatic logic [2:0] decode_type(input logic [7:0] code);
        logic [2:0] t;
        case (code)
            8'd1:    t = VT_U8;
            8'd2:    t = VT_U16;
            8'd4:    t = VT_U32;
            8'd17:   t = VT_S8;
            8'd18:   t = VT_S16;
            8'd20:   t = VT_S32;
            8'd36:   t = VT_F32;
            default: t = VT_INVALID;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

[hdl/tpd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_fifo
// Small register FIFO; head entry visible while not empty.
// ----------------------------------------------------------------------------
module tpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[hdl/tpd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_front
// Frame parser: tracks the packet phase, assembles field bytes, issues requests.
// ----------------------------------------------------------------------------
module tpd_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [7:0]  in_byte,
    input  wire logic        answer_errors,
    output logic             cmd_push,
    output tpd_pkg::cmd_t    cmd_data
);
    tpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0] id_reg, id_next;
    logic [2:0] type_reg, type_next;
    logic [2:0] expected_reg, expected_next;
    logic [2:0] taken_reg, taken_next;
    logic [7:0] asm_reg [4];
    logic [7:0] asm_next [4];
    logic [2:0] code_type;
    logic [2:0] taken_inc;

    assign code_type = tpd_pkg::decode_type(in_byte);
    assign taken_inc = taken_reg + 3'd1;

    // phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        if (in_valid)
        begin
            case (phase_reg)
                tpd_pkg::PH_HUNT:
                begin
                    if (in_byte == tpd_pkg::BYTE_START)
                    begin
                        phase_next = tpd_pkg::PH_ID;
                    end
                end
                tpd_pkg::PH_ID:
                begin
                    phase_next = tpd_pkg::PH_TYPE;
                end
                tpd_pkg::PH_TYPE:
                begin
                    if (in_byte == tpd_pkg::BYTE_END || code_type == tpd_pkg::VT_INVALID)
                    begin
                        phase_next = tpd_pkg::PH_HUNT;
                    end
                    else
                    begin
                        phase_next = tpd_pkg::PH_DATA;
                    end
                end
                tpd_pkg::PH_DATA:
                begin
                    if (taken_inc == expected_reg)
                    begin
                        phase_next = tpd_pkg::PH_TYPE;
                    end
                end
                default:
                begin
                    phase_next = tpd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // datapath and request generation
    always_comb
    begin
        id_next       = id_reg;
        type_next     = type_reg;
        expected_next = expected_reg;
        taken_next    = taken_reg;
        for (int i = 0; i < 4; i++)
        begin
            asm_next[i] = asm_reg[i];
        end
        cmd_push       = 1'b0;
        cmd_data.op    = tpd_pkg::OP_DONE;
        cmd_data.kind  = tpd_pkg::KIND_NONE;
        cmd_data.id    = id_reg;
        cmd_data.vtype = '0;
        cmd_data.bits  = '0;
        if (in_valid)
        begin
            case (phase_reg)
                tpd_pkg::PH_HUNT:
                begin
                    if (in_byte == tpd_pkg::BYTE_START)
                    begin
                        cmd_push    = 1'b1;
                        cmd_data.op = tpd_pkg::OP_CLEAR_U8;
                    end
                end
                tpd_pkg::PH_ID:
                begin
                    id_next = in_byte;
                end
                tpd_pkg::PH_TYPE:
                begin
                    if (in_byte == tpd_pkg::BYTE_END)
                    begin
                        cmd_push    = 1'b1;
                        cmd_data.op = tpd_pkg::OP_DONE;
                        if (id_reg == tpd_pkg::ID_IDENTIFY)
                        begin
                            cmd_data.kind = tpd_pkg::KIND_IDENTIFY;
                        end
                        else if (answer_errors)
                        begin
                            cmd_data.kind = tpd_pkg::KIND_ERROR;
                        end
                        else
                        begin
                            cmd_data.kind = tpd_pkg::KIND_NONE;
                        end
                    end
                    else if (code_type != tpd_pkg::VT_INVALID)
                    begin
                        type_next     = code_type;
                        expected_next = in_byte[2:0] & tpd_pkg::LEN_MASK[2:0];
                        taken_next    = '0;
                    end
                end
                tpd_pkg::PH_DATA:
                begin
                    asm_next[taken_reg[1:0]] = in_byte;
                    taken_next               = taken_inc;
                    if (taken_inc == expected_reg)
                    begin
                        cmd_push       = 1'b1;
                        cmd_data.op    = tpd_pkg::OP_VALUE;
                        cmd_data.kind  = tpd_pkg::KIND_VALUE;
                        cmd_data.vtype = type_reg;
                        // 2-byte fields big-endian, 4-byte fields little-endian
                        if (expected_reg == 3'd1)
                        begin
                            cmd_data.bits = {24'd0, asm_next[0]};
                        end
                        else if (expected_reg == 3'd2)
                        begin
                            cmd_data.bits = {16'd0, asm_next[0], asm_next[1]};
                        end
                        else
                        begin
                            cmd_data.bits = {asm_next[3], asm_next[2], asm_next[1], asm_next[0]};
                        end
                    end
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tpd_pkg::PH_HUNT;
            expected_reg <= '0;
            taken_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            taken_reg    <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        type_reg <= type_next;
        for (int i = 0; i < 4; i++)
        begin
            asm_reg[i] <= asm_next[i];
        end
    end

endmodule
`default_nettype wire

[hdl/tpd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_back
// Slot stage: keeps per-type slot counters and builds the result items.
// ----------------------------------------------------------------------------
module tpd_back #(
    parameter int SLOTS_PER_TYPE = tpd_pkg::SLOTS_PER_TYPE_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_empty,
    input  wire tpd_pkg::cmd_t  cmd_data,
    output logic                cmd_pop,
    input  wire logic           res_full,
    output logic                res_push,
    output tpd_pkg::result_t    res_data
);
    localparam int CNT_W = $clog2(SLOTS_PER_TYPE + 1);

    logic [CNT_W-1:0] cnt_reg [tpd_pkg::NUM_TYPES];
    logic [CNT_W-1:0] cnt_next [tpd_pkg::NUM_TYPES];
    logic [CNT_W-1:0] cnt_sel;
    logic             sat;

    assign cmd_pop = !cmd_empty && !res_full;
    assign cnt_sel = cnt_reg[cmd_data.vtype];
    assign sat     = (cnt_sel >= CNT_W'(SLOTS_PER_TYPE));

    always_comb
    begin
        for (int i = 0; i < tpd_pkg::NUM_TYPES; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        res_push          = 1'b0;
        res_data.kind     = cmd_data.kind;
        res_data.id       = cmd_data.id;
        res_data.vtype    = '0;
        res_data.bits     = '0;
        res_data.slot     = '0;
        res_data.overflow = 1'b0;
        if (cmd_pop)
        begin
            case (cmd_data.op)
                tpd_pkg::OP_CLEAR_U8:
                begin
                    cnt_next[tpd_pkg::VT_U8] = '0;
                end
                tpd_pkg::OP_VALUE:
                begin
                    res_push       = 1'b1;
                    res_data.vtype = cmd_data.vtype;
                    res_data.bits  = cmd_data.bits;
                    if (sat)
                    begin
                        res_data.overflow = 1'b1;
                    end
                    else
                    begin
                        res_data.slot           = 4'(cnt_sel);
                        cnt_next[cmd_data.vtype] = cnt_sel + 1'b1;
                    end
                end
                tpd_pkg::OP_DONE:
                begin
                    res_push = 1'b1;
                end
                default:
                begin
                    res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tpd_pkg::NUM_TYPES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < tpd_pkg::NUM_TYPES; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule
`default_nettype wire

[hdl/typed_packet_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// typed_packet_deframer
// Parses framed, typed-field packets from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue side: drive rx_byte with push; the byte is taken at an edge
//    where push is high and full is low. One byte per cycle is sustained.
//  - Result queue side: while empty is low the oldest result sits on the
//    result ports; raise pop to take it. One result per cycle is sustained.
//  - Path: a byte that completes a field or a packet has its result pass
//    from the parser into the request queue, then through the slot stage
//    into the result queue, which presents it on the ports.
//  - Config: answer_errors is written through cfg_valid/cfg_data; cfg_ready
//    is always high. Write only while the block is idle.
//  - Reset (rst_n low, asynchronous): parser hunts for a start byte, slot
//    counters are cleared, both queues empty, answer_errors cleared.
//  - When the receiver stops popping, the two-entry result queue fills,
//    then the two-entry request queue, then full rises; no result is lost.
// ----------------------------------------------------------------------------
module typed_packet_deframer #(
    parameter int SLOTS_PER_TYPE = tpd_pkg::SLOTS_PER_TYPE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // input queue side
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    // result queue side
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       event_kind,
    output logic [7:0]       packet_id,
    output logic [2:0]       value_type,
    output logic [31:0]      value_bits,
    output logic [3:0]       slot_index,
    output logic             slot_overflow
);
    logic             answer_errors_reg;
    logic             in_valid;
    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    tpd_pkg::cmd_t    cmd_in;
    tpd_pkg::cmd_t    cmd_out;
    logic             res_push;
    logic             res_full;
    tpd_pkg::result_t res_in;
    tpd_pkg::result_t res_out;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    // every accepted byte may raise one request, so a free request slot
    // is all the parser needs
    assign in_valid  = push && !cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_errors_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            answer_errors_reg <= cfg_data;
        end
    end

    tpd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_byte       (rx_byte),
        .answer_errors (answer_errors_reg),
        .cmd_push      (cmd_push),
        .cmd_data      (cmd_in)
    );

    // request queue between parser and slot stage
    tpd_fifo #(
        .WIDTH ($bits(tpd_pkg::cmd_t)),
        .DEPTH (tpd_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    tpd_back #(
        .SLOTS_PER_TYPE (SLOTS_PER_TYPE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    // result queue presented on the output ports
    tpd_fifo #(
        .WIDTH ($bits(tpd_pkg::result_t)),
        .DEPTH (tpd_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign event_kind    = res_out.kind;
    assign packet_id     = res_out.id;
    assign value_type    = res_out.vtype;
    assign value_bits    = res_out.bits;
    assign slot_index    = res_out.slot;
    assign slot_overflow = res_out.overflow;

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the typed packet deframer. A cycle-free predictor
// tracks the parser and the slot counters from the bytes the block accepts
// and queues the results it should emit; every popped result is checked
// against the oldest of them. Stimulus is a short hand-written opening, then
// random packets (mostly well formed, some aborted or cut short, plus stray
// bytes), with random idling on both queue sides and a long pop hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    // type codes as they appear on the wire
    localparam logic [7:0] CODE_U8  = 8'd1;
    localparam logic [7:0] CODE_U16 = 8'd2;
    localparam logic [7:0] CODE_U32 = 8'd4;
    localparam logic [7:0] CODE_S8  = 8'd17;
    localparam logic [7:0] CODE_S16 = 8'd18;
    localparam logic [7:0] CODE_S32 = 8'd20;
    localparam logic [7:0] CODE_F32 = 8'd36;
    localparam logic [7:0] CODE_BAD = 8'd3;

    localparam int SLOT_LIMIT    = tpd_pkg::SLOTS_PER_TYPE_DEF;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 8;      // settle margin after the last expected result is back
    localparam int HOLD_AFTER    = 150;    // results popped before the long hold
    localparam int LONG_HOLD     = 250;    // cycles of the long pop hold-off
    localparam int MAX_REPORTS   = 40;
    localparam int TIMEOUT_NS    = 1000000;

    // ------------------------------------------------------------------------
    // Predictor and store of expected results
    // ------------------------------------------------------------------------
    class deframer_scoreboard;
        bit               answer_errors;
        tpd_pkg::phase_t  phase;
        logic [7:0]       cur_id;
        logic [2:0]       cur_type;
        logic [2:0]       need_bytes;
        logic [2:0]       got_bytes;
        logic [7:0]       field_buf [4];
        logic [4:0]       slots_used [tpd_pkg::NUM_TYPES];
        tpd_pkg::result_t pending [$];
        int               errors;

        function new();
            answer_errors = 1'b0;
            phase         = tpd_pkg::PH_HUNT;
            cur_id        = '0;
            cur_type      = '0;
            need_bytes    = '0;
            got_bytes     = '0;
            errors        = 0;
            foreach (field_buf[i]) field_buf[i] = '0;
            foreach (slots_used[i]) slots_used[i] = '0;
        endfunction

        function logic [2:0] code_to_type(logic [7:0] code);
            logic [2:0] t;
            case (code)
                CODE_U8:  t = tpd_pkg::VT_U8;
                CODE_U16: t = tpd_pkg::VT_U16;
                CODE_U32: t = tpd_pkg::VT_U32;
                CODE_S8:  t = tpd_pkg::VT_S8;
                CODE_S16: t = tpd_pkg::VT_S16;
                CODE_S32: t = tpd_pkg::VT_S32;
                CODE_F32: t = tpd_pkg::VT_F32;
                default:  t = tpd_pkg::VT_INVALID;
            endcase
            return t;
        endfunction

        // one accepted byte; queues the result it completes, if any
        function void note_byte(logic [7:0] b);
            tpd_pkg::result_t r;
            logic [2:0]       t;
            logic [4:0]       used;
            r = '0;
            case (phase)
                tpd_pkg::PH_HUNT:
                    if (b == tpd_pkg::BYTE_START)
                    begin
                        phase = tpd_pkg::PH_ID;
                        slots_used[tpd_pkg::VT_U8] = '0;
                    end
                tpd_pkg::PH_ID:
                begin
                    cur_id = b;
                    phase  = tpd_pkg::PH_TYPE;
                end
                tpd_pkg::PH_TYPE:
                    if (b == tpd_pkg::BYTE_END)
                    begin
                        if (cur_id == tpd_pkg::ID_IDENTIFY)
                            r.kind = tpd_pkg::KIND_IDENTIFY;
                        else if (answer_errors)
                            r.kind = tpd_pkg::KIND_ERROR;
                        else
                            r.kind = tpd_pkg::KIND_NONE;
                        r.id = cur_id;
                        pending.push_back(r);
                        phase = tpd_pkg::PH_HUNT;
                    end
                    else
                    begin
                        t = code_to_type(b);
                        if (t == tpd_pkg::VT_INVALID)
                            phase = tpd_pkg::PH_HUNT;
                        else
                        begin
                            cur_type   = t;
                            need_bytes = 3'(b & 8'(tpd_pkg::LEN_MASK));
                            got_bytes  = '0;
                            phase      = tpd_pkg::PH_DATA;
                        end
                    end
                default:
                begin
                    field_buf[got_bytes[1:0]] = b;
                    got_bytes = got_bytes + 3'd1;
                    if (got_bytes == need_bytes)
                    begin
                        r.kind  = tpd_pkg::KIND_VALUE;
                        r.id    = cur_id;
                        r.vtype = cur_type;
                        // two bytes arrive high first, four bytes low first
                        if (need_bytes == 3'd1)
                            r.bits = {24'd0, field_buf[0]};
                        else if (need_bytes == 3'd2)
                            r.bits = {16'd0, field_buf[0], field_buf[1]};
                        else
                            r.bits = {field_buf[3], field_buf[2], field_buf[1], field_buf[0]};
                        used = slots_used[cur_type];
                        if (used >= 5'(SLOT_LIMIT))
                            r.overflow = 1'b1;
                        else
                        begin
                            r.slot = used[3:0];
                            slots_used[cur_type] = used + 5'd1;
                        end
                        pending.push_back(r);
                        phase = tpd_pkg::PH_TYPE;
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
            end
        endfunction

        function void check_result(tpd_pkg::result_t seen);
            tpd_pkg::result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result expected none, got kind %0d id %0h bits %0h",
                             $time, seen.kind, seen.id, seen.bits);
                return;
            end
            want = pending.pop_front();
            compare_field("event_kind",    32'(want.kind),     32'(seen.kind));
            compare_field("packet_id",     32'(want.id),       32'(seen.id));
            compare_field("value_type",    32'(want.vtype),    32'(seen.vtype));
            compare_field("value_bits",    want.bits,          seen.bits);
            compare_field("slot_index",    32'(want.slot),     32'(seen.slot));
            compare_field("slot_overflow", 32'(want.overflow), 32'(seen.overflow));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        push      = 1'b0;
    logic [7:0]  rx_byte   = '0;
    logic        pop       = 1'b0;
    logic        cfg_ready;
    logic        full;
    logic        empty;
    logic [1:0]  event_kind;
    logic [7:0]  packet_id;
    logic [2:0]  value_type;
    logic [31:0] value_bits;
    logic [3:0]  slot_index;
    logic        slot_overflow;

    deframer_scoreboard sb = new();

    bit      idle_on   = 1'b1;   // random gaps on both sides; off for the last phase
    int      fed       = 0;      // bytes that count towards the random budget
    int      popped    = 0;
    int      stall_left = 0;
    bit      hold_done = 1'b0;
    tpd_pkg::result_t seen_result;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    typed_packet_deframer #(
        .SLOTS_PER_TYPE(SLOT_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .event_kind   (event_kind),
        .packet_id    (packet_id),
        .value_type   (value_type),
        .value_bits   (value_bits),
        .slot_index   (slot_index),
        .slot_overflow(slot_overflow)
    );

    // ------------------------------------------------------------------------
    // Result side: pop with random gaps, one long hold-off once the run is
    // under way so that both internal queues fill and full rises.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            seen_result.kind     = tpd_pkg::event_kind_t'(event_kind);
            seen_result.id       = packet_id;
            seen_result.vtype    = value_type;
            seen_result.bits     = value_bits;
            seen_result.slot     = slot_index;
            seen_result.overflow = slot_overflow;
            sb.check_result(seen_result);
            popped++;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (!hold_done && popped >= HOLD_AFTER)
        begin
            hold_done  = 1'b1;
            stall_left = LONG_HOLD - 1;
            pop <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 14);   // burst includes this cycle
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // offer one byte; returns at the edge where the request is taken
    task automatic send_byte(input logic [7:0] b, input bit stray = 1'b0);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full !== 1'b0) @(posedge clk);
        sb.note_byte(b);
        if (!stray)
            fed++;
    endtask

    // sender pause: nothing offered until every expected result is back,
    // then a settle pause for bytes that produce no result
    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_answer_errors(input bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.answer_errors = v;
    endtask

    function automatic logic [7:0] type_code(input logic [2:0] vt);
        logic [7:0] c;
        case (vt)
            tpd_pkg::VT_U8:   c = CODE_U8;
            tpd_pkg::VT_U16:  c = CODE_U16;
            tpd_pkg::VT_U32:  c = CODE_U32;
            tpd_pkg::VT_S8:   c = CODE_S8;
            tpd_pkg::VT_S16:  c = CODE_S16;
            tpd_pkg::VT_S32:  c = CODE_S32;
            default:          c = CODE_F32;
        endcase
        return c;
    endfunction

    task automatic send_field(input logic [2:0] vt);
        logic [7:0]  code;
        logic [31:0] v;
        int          pick;
        code = type_code(vt);
        pick = $urandom_range(0, 5);
        if (pick == 0)
            v = '0;
        else if (pick == 1)
            v = '1;
        else
            v = $urandom;
        send_byte(code);
        for (int k = 0; k < int'(code & 8'(tpd_pkg::LEN_MASK)); k++)
            send_byte(v[8*k +: 8]);
    endtask

    // a packet with random content; most end cleanly, some abort on a bad
    // code, some are cut short so the next start byte lands mid-packet
    task automatic send_packet();
        logic [7:0] id;
        logic [7:0] bad;
        int         n_fields;
        bit         u8_run;
        int         ending;
        send_byte(tpd_pkg::BYTE_START);
        id = ($urandom_range(0, 3) == 0) ? tpd_pkg::ID_IDENTIFY
                                         : 8'($urandom_range(0, 255));
        send_byte(id);
        // long runs of u8 fields can push the per-packet u8 counter into overflow
        u8_run   = ($urandom_range(0, 9) == 0);
        n_fields = u8_run ? $urandom_range(16, 20) : $urandom_range(0, 5);
        for (int f = 0; f < n_fields; f++)
        begin
            if (u8_run && $urandom_range(0, 3) != 0)
                send_field(tpd_pkg::VT_U8);
            else
                send_field(3'($urandom_range(0, 6)));
        end
        ending = $urandom_range(0, 9);
        if (ending < 8)
            send_byte(tpd_pkg::BYTE_END);
        else if (ending == 8)
        begin
            do
                bad = 8'($urandom_range(0, 255));
            while (bad == tpd_pkg::BYTE_END || sb.code_to_type(bad) != tpd_pkg::VT_INVALID);
            send_byte(bad);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] opening [$];
        logic [7:0] aborts [$];
        int target;

        // stray bytes, then an identify packet with u8, u16 and s8 fields;
        // the payloads carry the framing values
        opening = '{
            8'h00, tpd_pkg::BYTE_END, 8'hFF,
            tpd_pkg::BYTE_START, tpd_pkg::ID_IDENTIFY,
            CODE_U8, 8'h00, CODE_U16, tpd_pkg::BYTE_START, tpd_pkg::BYTE_END,
            CODE_S8, tpd_pkg::BYTE_END,
            tpd_pkg::BYTE_END
        };
        // with error replies on: s16 and float fields, a bad code, a start
        // byte in the type position, and an error reply
        aborts = '{
            tpd_pkg::BYTE_START, tpd_pkg::BYTE_START,
            CODE_S16, 8'hFF, 8'h7F, CODE_F32, 8'h01, 8'h02, 8'h03, 8'h04, CODE_BAD,
            tpd_pkg::BYTE_START, 8'h07, tpd_pkg::BYTE_END,
            tpd_pkg::BYTE_START, 8'h00, tpd_pkg::BYTE_START
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_answer_errors(1'b0);
        foreach (opening[i]) send_byte(opening[i], 1'b1);
        drain();
        write_answer_errors(1'b1);
        foreach (aborts[i]) send_byte(aborts[i], 1'b1);

        // random phases, the setting swapped between each; the last has no idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_answer_errors(ph[0]);
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            target = fed + RANDOM_ITEMS / PHASES;
            while (fed < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b1);
                send_packet();
            end
        end
        drain();

        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
